// File: sv/lrupr_pkg.sv
// Shared types and constants for the LRU page-frame table.
// No dependencies; imported by every module of the block.
package lrupr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // fixed port widths
  localparam int PAGE_W     = 16;
  localparam int CFG_W      = 4;
  localparam int SLOT_OUT_W = 3;
  localparam int CNT_W      = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(8);
  localparam logic [CNT_W-1:0] CNT_MAX         = '1;

  // decision for one reference
  typedef struct packed {
    logic hit;
    logic fill;
    logic evict;
  } lrupr_dec_t;

endpackage

// File: sv/lrupr_select.sv
// Frame selection for the LRU table: tag compare, free-frame search, LRU victim.
// Pure combinational; depends on lrupr_pkg.
module lrupr_select #(
  parameter int FRAMES = lrupr_pkg::FRAMES_DEF,
  parameter int PW     = lrupr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic [FRAMES-1:0]              valid,
  input  logic [FRAMES-1:0][PW-1:0]      pages,
  input  logic [FRAMES-1:0][SLOT_W-1:0]  ranks,
  input  logic [PW-1:0]                  page,
  input  logic [lrupr_pkg::CFG_W-1:0]    frame_count,
  output lrupr_pkg::lrupr_dec_t          dec,
  output logic [SLOT_W-1:0]              slot
);
  import lrupr_pkg::*;

  localparam int USED_W = $clog2(FRAMES + 1);
  localparam int CMP_W  = ((USED_W > CFG_W) ? USED_W : CFG_W) + 1;

  logic [FRAMES-1:0] match;
  logic [FRAMES-1:0] oldest;
  logic [SLOT_W-1:0] match_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [SLOT_W-1:0] old_slot;
  logic [USED_W-1:0] used;
  logic [USED_W-1:0] old_rank;
  logic [CMP_W-1:0]  fc_eff;
  logic              any_match;

  assign used     = USED_W'($countones(valid));
  assign old_rank = used - USED_W'(1);

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i]  = valid[i] && (pages[i] == page);
      oldest[i] = valid[i] && (USED_W'(ranks[i]) == old_rank);
    end
  end

  // priority encoders, lowest index wins
  always_comb begin
    match_slot = '0;
    free_slot  = '0;
    old_slot   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_slot = SLOT_W'(i);
      end
      if (!valid[i]) begin
        free_slot = SLOT_W'(i);
      end
      if (oldest[i]) begin
        old_slot = SLOT_W'(i);
      end
    end
  end

  // clamp frame count into 1 .. FRAMES
  always_comb begin
    fc_eff = CMP_W'(frame_count);
    if (fc_eff == '0) begin
      fc_eff = CMP_W'(1);
    end else if (fc_eff > CMP_W'(FRAMES)) begin
      fc_eff = CMP_W'(FRAMES);
    end
  end

  assign any_match = |match;

  always_comb begin
    dec.hit   = any_match;
    dec.fill  = !any_match && (CMP_W'(used) < fc_eff);
    dec.evict = !any_match && !(CMP_W'(used) < fc_eff);
    if (any_match) begin
      slot = match_slot;
    end else if (dec.fill) begin
      slot = free_slot;
    end else begin
      slot = old_slot;
    end
  end

endmodule

// File: sv/lru_page_replacement.sv
// Top level of the fully associative LRU page-frame table.
// Depends on lrupr_pkg and lrupr_select.
//
// Usage:
//   Input channel: drive in_page and in_start_run with start high; a word is
//   taken at every rising edge with start high and busy low. busy is always
//   low, so one reference can be issued every cycle.
//   Result channel: out_valid pulses for one cycle with the result word
//   (hit/fault, evicted page, frame slot, running totals). The receiver must
//   take it in that cycle; there is no way to stall the output.
//   From accept to out_valid a word passes one input register, then a
//   single pass of compare, victim search and rank update into the result
//   register. Throughput is one reference per cycle; the frame table is
//   updated in the same pass, so back-to-back references see each other.
//   Config: cfg_we writes cfg_wdata into frame_count (0 acts as 1, values
//   above FRAMES act as FRAMES). Write only while no reference is in flight.
//   Reset (rst_n low, synchronous): all frames invalid, counters zero,
//   frame_count back to 8, no result pending. in_start_run does the same
//   for the table and counters ahead of its own reference.
module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lrupr_pkg::PAGE_W-1:0]     in_page,
  input  logic                             in_start_run,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic                             out_fault,
  output logic                             out_evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]     out_evicted_page,
  output logic [lrupr_pkg::SLOT_OUT_W-1:0] out_frame_slot,
  output logic [lrupr_pkg::CNT_W-1:0]      out_hit_total,
  output logic [lrupr_pkg::CNT_W-1:0]      out_fault_total,
  input  logic                             cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]      cfg_wdata
);
  import lrupr_pkg::*;

  localparam int PW     = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // input register
  logic              in_valid_r;
  logic [PW-1:0]     page_r;
  logic              start_run_r;

  // frame table and counters
  logic [FRAMES-1:0]             valid_r, valid_nxt, valid_eff;
  logic [FRAMES-1:0][PW-1:0]     pages_r;
  logic [FRAMES-1:0][SLOT_W-1:0] ranks_r, ranks_nxt;
  logic [CNT_W-1:0]              hits_r, hits_nxt, hits_eff;
  logic [CNT_W-1:0]              faults_r, faults_nxt, faults_eff;
  logic [CFG_W-1:0]              frame_count_r;

  // result register
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic                  out_fault_r;
  logic                  out_ev_valid_r;
  logic [PAGE_W-1:0]     out_ev_page_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  lrupr_dec_t        dec;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] limit;
  logic              lim_all;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      page_r      <= in_page[PW-1:0];
      start_run_r <= in_start_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RST;
    end else if (cfg_we) begin
      frame_count_r <= cfg_wdata;
    end
  end

  // a new run sees an empty table
  assign valid_eff  = start_run_r ? '0 : valid_r;
  assign hits_eff   = start_run_r ? '0 : hits_r;
  assign faults_eff = start_run_r ? '0 : faults_r;

  lrupr_select #(
    .FRAMES (FRAMES),
    .PW     (PW),
    .SLOT_W (SLOT_W)
  ) u_select (
    .valid       (valid_eff),
    .pages       (pages_r),
    .ranks       (ranks_r),
    .page        (page_r),
    .frame_count (frame_count_r),
    .dec         (dec),
    .slot        (slot)
  );

  // on a hit only frames younger than the hit frame age; on a fault all age
  assign limit   = ranks_r[slot];
  assign lim_all = !dec.hit;

  always_comb begin
    valid_nxt = valid_eff;
    if (dec.fill) begin
      valid_nxt[slot] = 1'b1;
    end
    for (int i = 0; i < FRAMES; i++) begin
      ranks_nxt[i] = ranks_r[i];
      if (SLOT_W'(i) == slot) begin
        ranks_nxt[i] = '0;
      end else if (valid_eff[i] && (lim_all || ranks_r[i] < limit)) begin
        ranks_nxt[i] = ranks_r[i] + SLOT_W'(1);
      end
    end
    hits_nxt   = hits_eff;
    faults_nxt = faults_eff;
    if (dec.hit && hits_eff != CNT_MAX) begin
      hits_nxt = hits_eff + CNT_W'(1);
    end
    if (!dec.hit && faults_eff != CNT_MAX) begin
      faults_nxt = faults_eff + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      hits_r   <= '0;
      faults_r <= '0;
    end else if (in_valid_r) begin
      valid_r  <= valid_nxt;
      hits_r   <= hits_nxt;
      faults_r <= faults_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      ranks_r <= ranks_nxt;
      if (!dec.hit) begin
        pages_r[slot] <= page_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_hit_r      <= dec.hit;
      out_fault_r    <= !dec.hit;
      out_ev_valid_r <= dec.evict;
      out_ev_page_r  <= dec.evict ? PAGE_W'(pages_r[slot]) : '0;
      out_slot_r     <= SLOT_OUT_W'(slot);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_fault         = out_fault_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_frame_slot    = out_slot_r;
  assign out_hit_total     = hits_r;
  assign out_fault_total   = faults_r;

endmodule

// File: sv/lrupr_checker.sv
// Port-level checks for lru_page_replacement, bound to the top level.
// Depends on lrupr_pkg.
module lrupr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic                             out_hit,
  input logic                             out_fault,
  input logic                             out_evicted_valid,
  input logic [lrupr_pkg::PAGE_W-1:0]     out_evicted_page,
  input logic [lrupr_pkg::CNT_W-1:0]      out_fault_total,
  input logic [lrupr_pkg::CNT_W-1:0]      out_hit_total
);
  import lrupr_pkg::*;

  // every accepted word comes back on out_valid after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit != out_fault))
    else $error("result is not exactly one of hit and fault");

  a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> out_fault)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_hit && out_hit_total != '0) ||
                   (out_fault && out_fault_total != '0)))
    else $error("running total does not count this word");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_hit           (out_hit),
  .out_fault         (out_fault),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page),
  .out_fault_total   (out_fault_total),
  .out_hit_total     (out_hit_total)
);

// File: tb/sv/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
// Self-checking bench for lru_page_replacement: an LRU frame table predictor
// scores every result word. Depends on lrupr_pkg and the block's RTL.
module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int NUM_FRAMES = FRAMES_DEF;

  typedef struct {
    logic                  hit;
    logic                  fault;
    logic                  evicted_valid;
    logic [PAGE_W-1:0]     evicted_page;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      fault_total;
  } page_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [PAGE_W-1:0]     in_page;
  logic                  in_start_run;
  logic                  out_valid;
  logic                  out_hit;
  logic                  out_fault;
  logic                  out_evicted_valid;
  logic [PAGE_W-1:0]     out_evicted_page;
  logic [SLOT_OUT_W-1:0] out_frame_slot;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_fault_total;
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;

  // predictor state
  logic [PAGE_W-1:0] frame_page [NUM_FRAMES];
  bit                frame_used [NUM_FRAMES];
  int                frame_age  [NUM_FRAMES];
  logic [CNT_W-1:0]  hits_so_far;
  logic [CNT_W-1:0]  faults_so_far;
  logic [CFG_W-1:0]  frame_limit;

  page_result_t pending_results[$];
  int           mismatches = 0;

  lru_page_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page           (in_page),
    .in_start_run      (in_start_run),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_fault         (out_fault),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_frame_slot    (out_frame_slot),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void clear_frames();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_page[i] = '0;
      frame_used[i] = 1'b0;
      frame_age[i]  = 0;
    end
    hits_so_far   = '0;
    faults_so_far = '0;
  endfunction

  // age every used frame younger than lim, then make slot the newest
  function automatic void make_newest(int slot, int lim);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_used[i] && i != slot && frame_age[i] < lim) frame_age[i]++;
    end
    frame_age[slot] = 0;
  endfunction

  function automatic page_result_t lru_lookup(logic [PAGE_W-1:0] pg, logic clr);
    page_result_t r;
    int   lim;
    int   used;
    int   slot;
    int   oldest;
    bit   found;
    bit   any;
    r = '{default: '0};
    if (clr) clear_frames();
    lim = frame_limit;
    if (lim < 1) lim = 1;
    if (lim > NUM_FRAMES) lim = NUM_FRAMES;
    used  = 0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_used[i]) begin
        used++;
        if (!found && frame_page[i] == pg) begin
          found = 1'b1;
          slot  = i;
        end
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_newest(slot, frame_age[slot]);
      if (hits_so_far != CNT_MAX) hits_so_far++;
    end else begin
      r.fault = 1'b1;
      if (used < lim) begin
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
          if (!frame_used[i]) slot = i;
        end
        frame_used[slot] = 1'b1;
      end else begin
        // replace the oldest used frame, lowest index on a tie
        any    = 1'b0;
        oldest = 0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (frame_used[i] && (!any || frame_age[i] > oldest)) begin
            any    = 1'b1;
            oldest = frame_age[i];
            slot   = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[slot];
      end
      frame_page[slot] = pg;
      make_newest(slot, NUM_FRAMES);
      if (faults_so_far != CNT_MAX) faults_so_far++;
    end
    r.frame_slot  = slot[SLOT_OUT_W-1:0];
    r.hit_total   = hits_so_far;
    r.fault_total = faults_so_far;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // score results, track config writes and predict each accepted word
  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst_n) begin
      clear_frames();
      frame_limit = FRAME_COUNT_RST;
      pending_results.delete();
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result word with no reference pending");
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          check_field("hit", exp_r.hit, out_hit);
          check_field("fault", exp_r.fault, out_fault);
          check_field("evicted_valid", exp_r.evicted_valid, out_evicted_valid);
          check_field("evicted_page", exp_r.evicted_page, out_evicted_page);
          check_field("frame_slot", exp_r.frame_slot, out_frame_slot);
          check_field("hit_total", exp_r.hit_total, out_hit_total);
          check_field("fault_total", exp_r.fault_total, out_fault_total);
        end
      end
      if (cfg_we) frame_limit = cfg_wdata;
      if (start && !busy) pending_results.push_back(lru_lookup(in_page, in_start_run));
    end
  end

  int gap_pct = 0;

  task automatic send_ref(logic [PAGE_W-1:0] pg, logic clr);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_page      <= pg;
    in_start_run <= clr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start, let every result drain, then write the frame count
  task automatic set_frame_count(logic [CFG_W-1:0] fc);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= fc;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_fill_and_evict();
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    for (int p = 1; p <= 6; p++) send_ref(PAGE_W'(p), 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h5555, 1'b0);
    // clear, then clear again on a page that would have hit
    send_ref(16'h1234, 1'b1);
    send_ref(16'h1234, 1'b1);
  endtask

  task automatic test_frame_count_limits();
    // zero acts as a single frame
    set_frame_count(4'd0);
    send_ref(16'h0007, 1'b1);
    send_ref(16'h0008, 1'b0);
    send_ref(16'h0008, 1'b0);
    // above the frame total acts as all frames
    set_frame_count(4'd15);
    send_ref(16'h0100, 1'b1);
    for (int p = 1; p <= 8; p++) send_ref(PAGE_W'(16'h0100 + p), 1'b0);
  endtask

  task automatic test_shrink_in_use();
    // table is full; a lower count must keep every frame in use
    set_frame_count(4'd2);
    send_ref(16'h0200, 1'b0);
    send_ref(16'h0201, 1'b0);
    send_ref(16'h0105, 1'b0);
    send_ref(16'h0200, 1'b0);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] fc, int n_items);
    logic [PAGE_W-1:0] page_pool [16];
    int                pool_n;
    int                eff;
    int                roll;
    logic [PAGE_W-1:0] pg;
    eff = (fc == 0) ? 1 : (fc > NUM_FRAMES) ? NUM_FRAMES : fc;
    pool_n = eff + $urandom_range(1, 4);
    for (int i = 0; i < 16; i++) page_pool[i] = PAGE_W'($urandom_range(16'hFFFF));
    set_frame_count(fc);
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll >= 2 && roll < 10) pg = PAGE_W'($urandom_range(16'hFFFF));
      else pg = page_pool[$urandom_range(pool_n - 1)];
      send_ref(pg, roll < 2);
    end
  endtask

  initial begin
    int gaps [3];
    logic [CFG_W-1:0] fc;
    gaps = '{30, 77, 0};
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_page      <= '0;
    in_start_run <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_evict();
    test_frame_count_limits();
    test_shrink_in_use();

    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = gaps[ph];
      for (int seg = 0; seg < 7; seg++) begin
        case (seg)
          0:       fc = 4'd0;
          1:       fc = 4'd15;
          2:       fc = 4'd1;
          3:       fc = 4'd8;
          default: fc = CFG_W'($urandom_range(2, 7));
        endcase
        test_random_traffic(fc, 50);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
